// ===== hw/rtl/ffra_pkg.sv =====
`default_nettype none
package ffra_pkg;

   localparam int REGION_ENTRIES_DEF = 64;
   localparam int CELL_BYTES         = 8;

   localparam int ADDR_W  = 24;
   localparam int SIZE_W  = 25;
   localparam int BYTES_W = 32;
   localparam int NEED_W  = BYTES_W + 1;
   localparam int SPAN_W  = $clog2(CELL_BYTES + 1);

   localparam logic [SIZE_W-1:0] ADDR_SPACE_MAX = SIZE_W'(16 * 1024 * 1024);

   typedef enum logic [1:0] {
      KIND_ALLOC      = 2'd0,
      KIND_FREE       = 2'd1,
      KIND_CHECK_BYTE = 2'd2,
      KIND_CHECK_CELL = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD      = 3'd1,
      ST_OOM      = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      GRANT_NONE = 2'd0,
      GRANT_HIT  = 2'd1,
      GRANT_BUMP = 2'd2
   } grant_sel_type;

   typedef struct packed {
      logic          accept;
      logic          scan;
      logic          set_hit_used;
      logic          clr_hit_used;
      logic          write_new;
      logic          new_from_bump;
      logic          write_hit_size;
      logic          set_res;
      status_type    res_status;
      grant_sel_type res_grant;
      logic          load_out;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     bad;
      logic     hit;
      logic     scan_end;
      logic     split_need;
      logic     full;
      logic     oom;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ffra_dp.sv =====
`default_nettype none
module ffra_dp import ffra_pkg::*; #(
   parameter int REGION_ENTRIES = REGION_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_kind,
   input  logic [BYTES_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0]  req_address,
   input  logic               csr_write,
   input  logic [SIZE_W-1:0]  csr_mem_limit,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   output logic               rsp_ok,
   output logic [ADDR_W-1:0]  rsp_granted_address,
   output logic [2:0]         rsp_status
);

   localparam int IDX_W = $clog2(REGION_ENTRIES);
   localparam int CNT_W = $clog2(REGION_ENTRIES + 1);

   // request latched at accept
   kind_type            kind_ff, kind_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [ADDR_W-1:0]   addr_ff;
   logic [SPAN_W-1:0]   span_ff, span_in;
   logic                bad_ff, bad_in;
   logic [NEED_W-1:0]   need_sum;

   logic [SIZE_W-1:0]   mem_limit_ff;
   logic [SIZE_W-1:0]   limit_eff;

   logic [ADDR_W-1:0]   base_mem [REGION_ENTRIES];
   logic [SIZE_W-1:0]   size_mem [REGION_ENTRIES];

   logic [REGION_ENTRIES-1:0] used_ff, used_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SIZE_W-1:0]   bump_ff, bump_in;

   // scan pipeline
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]    ev_idx_ff;
   logic [ADDR_W-1:0]   ev_base_ff;
   logic [SIZE_W-1:0]   ev_size_ff;
   logic                ev_used_ff;
   logic [IDX_W-1:0]    rd_idx;
   logic                issue;

   logic [IDX_W-1:0]    hit_idx_ff;
   logic [ADDR_W-1:0]   hit_base_ff;
   logic [SIZE_W-1:0]   hit_size_ff;

   logic [ADDR_W-1:0]   off;
   logic [SIZE_W:0]     reach;
   logic                fit_chk, fit_alloc, match_free, hit_cond;

   logic [SIZE_W-1:0]   rem;
   logic [NEED_W:0]     bump_end;
   logic [IDX_W-1:0]    count_idx;
   logic [ADDR_W-1:0]   new_base;
   logic [SIZE_W-1:0]   new_size;
   logic                size_we;
   logic [IDX_W-1:0]    size_waddr;
   logic [SIZE_W-1:0]   size_wdata;

   status_type          res_status_ff;
   logic [ADDR_W-1:0]   res_grant_ff, res_grant_in;
   logic                rsp_ok_ff;
   logic [ADDR_W-1:0]   rsp_grant_ff;
   status_type          rsp_status_ff;

   // accept-time decode
   always_comb begin
      kind_in  = kind_type'(req_kind);
      need_sum = NEED_W'(req_request_bytes) + NEED_W'(CELL_BYTES - 1);
      need_in  = need_sum & ~NEED_W'(CELL_BYTES - 1);
      span_in  = (kind_in == KIND_CHECK_CELL) ? SPAN_W'(CELL_BYTES) : SPAN_W'(1);
      case (kind_in)
         KIND_ALLOC:      bad_in = (req_request_bytes == '0);
         KIND_FREE:       bad_in = (req_address == '0);
         KIND_CHECK_CELL: bad_in = ((req_address & ADDR_W'(CELL_BYTES - 1)) != '0);
         default:         bad_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= kind_in;
         need_ff <= need_in;
         addr_ff <= req_address;
         span_ff <= span_in;
         bad_ff  <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_limit_ff <= ADDR_SPACE_MAX;
      end else if (csr_write) begin
         mem_limit_ff <= csr_mem_limit;
      end
   end

   assign limit_eff = (mem_limit_ff > ADDR_SPACE_MAX) ? ADDR_SPACE_MAX : mem_limit_ff;

   // scan issue
   assign rd_idx = cnt_ff[IDX_W-1:0];
   assign issue  = cmd.scan && (cnt_ff < count_ff);

   always_comb begin
      cnt_in      = cnt_ff;
      ev_valid_in = 1'b0;
      if (cmd.accept) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in      = cnt_ff + CNT_W'(1);
         ev_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff  <= rd_idx;
      ev_used_ff <= used_ff[rd_idx];
   end

   // evaluate the entry read last cycle
   always_comb begin
      off        = addr_ff - ev_base_ff;
      reach      = (SIZE_W + 1)'(off) + (SIZE_W + 1)'(span_ff);
      fit_chk    = ev_used_ff && (addr_ff >= ev_base_ff) && (reach <= {1'b0, ev_size_ff});
      fit_alloc  = !ev_used_ff && (NEED_W'(ev_size_ff) >= need_ff);
      match_free = ev_used_ff && (ev_base_ff == addr_ff);
      case (kind_ff)
         KIND_ALLOC: hit_cond = fit_alloc;
         KIND_FREE:  hit_cond = match_free;
         default:    hit_cond = fit_chk;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && stat.hit) begin
         hit_idx_ff  <= ev_idx_ff;
         hit_base_ff <= ev_base_ff;
         hit_size_ff <= ev_size_ff;
      end
   end

   assign rem       = hit_size_ff - need_ff[SIZE_W-1:0];
   assign bump_end  = (NEED_W + 1)'(bump_ff) + (NEED_W + 1)'(need_ff);
   assign count_idx = count_ff[IDX_W-1:0];

   always_comb begin
      stat.kind       = kind_ff;
      stat.bad        = bad_ff;
      stat.hit        = ev_valid_ff && hit_cond;
      stat.scan_end   = !ev_valid_ff && !(cnt_ff < count_ff);
      stat.split_need = (rem >= SIZE_W'(CELL_BYTES));
      stat.full       = (count_ff == CNT_W'(REGION_ENTRIES));
      stat.oom        = (bump_end > (NEED_W + 1)'(limit_eff));
   end

   // table writes
   always_comb begin
      if (cmd.new_from_bump) begin
         new_base = bump_ff[ADDR_W-1:0];
         new_size = need_ff[SIZE_W-1:0];
      end else begin
         new_base = hit_base_ff + need_ff[ADDR_W-1:0];
         new_size = rem;
      end
      size_we    = cmd.write_new || cmd.write_hit_size;
      size_waddr = cmd.write_hit_size ? hit_idx_ff : count_idx;
      size_wdata = cmd.write_hit_size ? need_ff[SIZE_W-1:0] : new_size;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         base_mem[count_idx] <= new_base;
      end
      ev_base_ff <= base_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      ev_size_ff <= size_mem[rd_idx];
   end

   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      bump_in  = bump_ff;
      if (cmd.set_hit_used) begin
         used_in[hit_idx_ff] = 1'b1;
      end
      if (cmd.clr_hit_used) begin
         used_in[hit_idx_ff] = 1'b0;
      end
      if (cmd.write_new) begin
         used_in[count_idx] = cmd.new_from_bump;
         count_in           = count_ff + CNT_W'(1);
         if (cmd.new_from_bump) begin
            bump_in = bump_ff + need_ff[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
         bump_ff  <= SIZE_W'(CELL_BYTES);
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
         bump_ff  <= bump_in;
      end
   end

   // result and output beat
   always_comb begin
      case (cmd.res_grant)
         GRANT_HIT:  res_grant_in = hit_base_ff;
         GRANT_BUMP: res_grant_in = bump_ff[ADDR_W-1:0];
         default:    res_grant_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_grant_ff  <= res_grant_in;
      end
      if (cmd.load_out) begin
         rsp_ok_ff     <= (res_status_ff == ST_OK);
         rsp_grant_ff  <= res_grant_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_ok              = rsp_ok_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_status          = rsp_status_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ffra_ctrl.sv =====
`default_nettype none
module ffra_ctrl import ffra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_HIT    = 6'b000100,
      S_SPLIT  = 6'b001000,
      S_BUMP   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in           = state_ff;
      cmd.accept         = 1'b0;
      cmd.scan           = 1'b0;
      cmd.set_hit_used   = 1'b0;
      cmd.clr_hit_used   = 1'b0;
      cmd.write_new      = 1'b0;
      cmd.new_from_bump  = 1'b0;
      cmd.write_hit_size = 1'b0;
      cmd.set_res        = 1'b0;
      cmd.res_status     = ST_OK;
      cmd.res_grant      = GRANT_NONE;
      cmd.load_out       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.bad) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_BAD;
               state_in       = S_FINISH;
            end else if (stat.hit) begin
               state_in = S_HIT;
            end else if (stat.scan_end) begin
               if (stat.kind == KIND_ALLOC) begin
                  state_in = S_BUMP;
               end else begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_NOTFOUND;
                  state_in       = S_FINISH;
               end
            end
         end
         S_HIT: begin
            state_in    = S_FINISH;
            cmd.set_res = 1'b1;
            case (stat.kind)
               KIND_ALLOC: begin
                  if (stat.split_need) begin
                     if (stat.full) begin
                        cmd.res_status = ST_FULL;
                     end else begin
                        cmd.set_res   = 1'b0;
                        cmd.write_new = 1'b1;
                        state_in      = S_SPLIT;
                     end
                  end else begin
                     cmd.set_hit_used = 1'b1;
                     cmd.res_grant    = GRANT_HIT;
                  end
               end
               KIND_FREE: begin
                  cmd.clr_hit_used = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_SPLIT: begin
            cmd.write_hit_size = 1'b1;
            cmd.set_hit_used   = 1'b1;
            cmd.set_res        = 1'b1;
            cmd.res_grant      = GRANT_HIT;
            state_in           = S_FINISH;
         end
         S_BUMP: begin
            cmd.set_res = 1'b1;
            state_in    = S_FINISH;
            if (stat.oom) begin
               cmd.res_status = ST_OOM;
            end else if (stat.full) begin
               cmd.res_status = ST_FULL;
            end else begin
               cmd.write_new     = 1'b1;
               cmd.new_from_bump = 1'b1;
               cmd.res_grant     = GRANT_BUMP;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_region_allocator.sv =====
// First-fit region allocator with bump-pointer fallback.
// Request channel (req_*): kind, request_bytes, address; a beat is taken when
// req_valid is high and req_stall is low. One request is worked at a time;
// req_stall is high from the accepting edge until its result is registered.
// Result channel (rsp_*): ok, granted_address, status; a beat is taken when
// rsp_valid is high and rsp_stall is low. The result stays in the output
// register while the receiver stalls, and the next request is taken then.
// Flow: the region table is scanned one entry per cycle through the
// registered read of the region memory. A hit goes to S_HIT, a split adds
// S_SPLIT, and an alloc miss goes to S_BUMP for a bump carve; the result is
// then loaded out from S_FINISH. The next request is taken only after that
// load, so the scan sets the throughput.
// csr_*: one write channel for mem_limit, csr_ready is always high; write it
// only while no request is in flight.
// Reset: table empty, bump pointer at one cell, mem_limit at 16 MiB, no
// result pending. The region memory needs no clearing pass.
`default_nettype none
module first_fit_region_allocator import ffra_pkg::*; #(
   parameter int REGION_ENTRIES = REGION_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [BYTES_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0]  req_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [ADDR_W-1:0]  rsp_granted_address,
   output logic [2:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SIZE_W-1:0]  csr_mem_limit
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   ffra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffra_dp #(
      .REGION_ENTRIES (REGION_ENTRIES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_request_bytes   (req_request_bytes),
      .req_address         (req_address),
      .csr_write           (csr_write),
      .csr_mem_limit       (csr_mem_limit),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_ok              (rsp_ok),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status)
   );

   a_ok_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ok == (rsp_status == ST_OK)))
      else $error("ok flag disagrees with status");

   a_no_grant_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_granted_address == '0))
      else $error("granted address nonzero on failed request");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in flight");

endmodule
`default_nettype wire
